// ===== rtl/lpmt_pkg.sv =====
`default_nettype none

package lpmt_pkg;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam int  ADDR_W  = 32;
    localparam int  SLOT_W  = 4;
    localparam int  PLEN_W  = 6;
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_dest;
        logic [PLEN_W-1:0] entry_prefix_len;
        logic              entry_valid;
        logic [ADDR_W-1:0] lookup_addr;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] match_index;
        logic [PLEN_W-1:0] match_prefix_len;
    } rsp_t;

    typedef struct packed {
        logic              vld;
        req_t              req;
        logic              hit;
        logic [SLOT_W-1:0] best_idx;
        logic [PLEN_W-1:0] best_len;
    } word_t;

    // Mask with len leading ones; len is at most 32 once stored.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

    function automatic logic [PLEN_W-1:0] sat_len(input logic [PLEN_W-1:0] len);
        sat_len = (len > PLEN_MAX) ? PLEN_MAX : len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lpmt_cell.sv =====
`default_nettype none

module lpmt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire lpmt_pkg::word_t  word_in,
    output lpmt_pkg::word_t       word_out
);
    import lpmt_pkg::*;

    logic [ADDR_W-1:0] dest_reg;
    logic [PLEN_W-1:0] len_reg;
    logic              valid_reg;
    logic              vld_reg;
    word_t             word_reg;
    word_t             word_next;
    logic              wr_en;
    logic              match;
    logic [ADDR_W-1:0] mask;

    assign wr_en = advance && word_in.vld && (word_in.req.func == FUNC_WRITE)
                   && (32'(word_in.req.entry_index) == 32'(CELL_INDEX));
    assign mask  = prefix_mask(len_reg);
    assign match = valid_reg && (word_in.req.func == FUNC_LOOKUP)
                   && ((dest_reg & mask) == (word_in.req.lookup_addr & mask));

    always_comb
    begin
        word_next = word_in;
        if (match && (!word_in.hit || (len_reg >= word_in.best_len)))
        begin
            word_next.hit      = 1'b1;
            word_next.best_idx = SLOT_W'(CELL_INDEX);
            word_next.best_len = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg <= word_in.req.entry_valid;
            end
            if (advance)
            begin
                vld_reg <= word_in.vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_reg <= word_in.req.entry_dest;
            len_reg  <= sat_len(word_in.req.entry_prefix_len);
        end
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        word_out     = word_reg;
        word_out.vld = vld_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/longest_prefix_match_table.sv =====
`default_nettype none

// Each word passes one table cell per cycle unless the output stalls, and its result is
// held in the output register after the last of the TABLE_DEPTH cells.
// Throughput is one word per cycle; a stalled output holds the whole cell chain.
// Reset (rst_n, asynchronous, active low) marks all entries invalid and empties the chain.
module longest_prefix_match_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire lpmt_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output lpmt_pkg::rsp_t       rsp
);
    import lpmt_pkg::*;

    word_t chain [TABLE_DEPTH+1];
    logic  advance;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;

    always_comb
    begin
        chain[0].vld      = req_valid;
        chain[0].req      = req;
        chain[0].hit      = 1'b0;
        chain[0].best_idx = '0;
        chain[0].best_len = '0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        lpmt_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= chain[TABLE_DEPTH].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.hit              <= chain[TABLE_DEPTH].hit;
            rsp_reg.match_index      <= chain[TABLE_DEPTH].best_idx;
            rsp_reg.match_prefix_len <= chain[TABLE_DEPTH].best_len;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A miss reports slot zero and length zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.hit || (rsp.match_index == '0 && rsp.match_prefix_len == '0)))
        else $error("miss result carries nonzero fields");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.match_prefix_len <= PLEN_MAX))
        else $error("prefix length above 32");

    // While the output stalls, the word at the end of the chain must not move.
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain[TABLE_DEPTH].vld))
        else $error("cell chain moved during stall");

endmodule

`default_nettype wire
